/* hw/rtl/cil_pkg.sv */
// Shared types and constants for the cue interval lookup block.
// Used by cil_table, cue_interval_lookup_top and the testbench; depends on nothing else.
package cil_pkg;

  localparam int CIL_MAX_CUES   = 4096;
  localparam int CIL_IDX_W      = $clog2(CIL_MAX_CUES);
  localparam int CIL_CNT_W      = CIL_IDX_W + 1;
  localparam int CIL_TIME_W     = 32;
  localparam int CIL_WALK_AHEAD = 8;

  typedef enum logic [1:0] {
    KIND_CLEAR      = 2'd0,
    KIND_APPEND     = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_CURSOR_RST = 2'd3
  } cil_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_AHEAD,
    ST_WALK,
    ST_PREV,
    ST_SRCH,
    ST_FIN
  } cil_state_t;

  typedef struct packed {
    logic                  en;
    logic [CIL_IDX_W-1:0]  addr;
    logic [CIL_TIME_W-1:0] beg_ms;
    logic [CIL_TIME_W-1:0] end_ms;
  } cil_wr_t;

endpackage

/* hw/rtl/cue_interval_lookup_top.sv */
// Cue interval lookup: clear, append, query and cursor-reset transactions.
// Latency: clear, append and cursor reset give their result one cycle after accept and
// leave busy low, so a transaction may follow every cycle. A query on an empty table too.
// A query holds busy while it checks the cursor cue (and the previous cue if it is read), walks a
// short way forward or runs a binary search; its result follows the last busy cycle.
// Reset clears count, cursor, sequencer and the result strobe only.
module cue_interval_lookup_top import cil_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic [CIL_TIME_W-1:0] in_cue_start_ms,
  input  logic [CIL_TIME_W-1:0] in_cue_end_ms,
  input  logic                  in_cue_has_text,
  input  logic [CIL_TIME_W-1:0] in_query_time_ms,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [CIL_IDX_W-1:0]  out_cue_index,
  output logic                  out_accepted,
  output logic [CIL_CNT_W-1:0]  out_cue_total
);

  // Sequencer and architectural state
  cil_state_t            state_r, state_nxt;
  logic [CIL_CNT_W-1:0]  count_r, count_nxt;
  logic [CIL_CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CIL_TIME_W-1:0] t_r, t_nxt;

  // Binary search bounds
  logic [CIL_CNT_W-1:0]  lo_r, lo_nxt;
  logic [CIL_CNT_W-1:0]  hi_r, hi_nxt;
  logic [CIL_CNT_W-1:0]  mid_r, mid_nxt;
  logic [CIL_CNT_W-1:0]  best_r, best_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [CIL_IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic [CIL_CNT_W-1:0]  out_total_r, out_total_nxt;

  // Table interface
  cil_wr_t               wr;
  logic [CIL_IDX_W-1:0]  rd_addr;
  logic [CIL_TIME_W-1:0] rd_beg_ms;
  logic [CIL_TIME_W-1:0] rd_end_ms;

  // Shared compare and decision terms
  logic                  accept;
  cil_kind_t             kind;
  logic                  lt;
  logic                  cur_valid;
  logic                  ahead_ok;
  logic [CIL_CNT_W:0]    cur_ahead_w;
  logic [CIL_CNT_W-1:0]  cur_ahead;
  logic [CIL_CNT_W-1:0]  cur_inc;
  logic [CIL_CNT_W-1:0]  cur_dec;
  logic                  srch_init;
  logic [CIL_CNT_W-1:0]  lo_s, hi_s, best_s, mid_s;
  logic                  srch_more;
  logic                  append_ok;

  cil_table u_table (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_beg_ms (rd_beg_ms),
    .rd_end_ms (rd_end_ms)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign kind   = cil_kind_t'(in_kind);

  // The end-time comparator every query step leans on: has the cue just read ended?
  assign lt        = rd_end_ms < t_r;
  assign cur_valid = cursor_r < count_r;

  // Walk forward only when the cue eight places ahead has not ended yet
  assign cur_ahead_w = {1'b0, cursor_r} + (CIL_CNT_W + 1)'(CIL_WALK_AHEAD);
  assign cur_ahead   = cur_ahead_w[CIL_CNT_W-1:0];
  assign ahead_ok    = cur_valid && lt && (cur_ahead_w < {1'b0, count_r});
  assign cur_inc     = cursor_r + CIL_CNT_W'(1);
  assign cur_dec     = cursor_r - CIL_CNT_W'(1);

  // One lower-bound step per cycle; the next probe issues in the same cycle
  always_comb begin
    lo_s   = lo_r;
    hi_s   = hi_r;
    best_s = best_r;
    if (lt) begin
      lo_s = mid_r + CIL_CNT_W'(1);
    end else begin
      hi_s   = mid_r;
      best_s = mid_r;
    end
    mid_s     = lo_s + ((hi_s - lo_s) >> 1);
    srch_more = lo_s < hi_s;
  end

  assign append_ok = in_cue_has_text && (in_cue_end_ms > in_cue_start_ms) &&
                     (count_r < CIL_CNT_W'(CIL_MAX_CUES));

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && kind == KIND_QUERY && count_r != '0) begin
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        if (!cur_valid || lt) begin
          state_nxt = ahead_ok ? ST_AHEAD : ST_SRCH;
        end else begin
          state_nxt = (cursor_r != '0) ? ST_PREV : ST_FIN;
        end
      end
      ST_AHEAD: state_nxt = lt ? ST_SRCH : ST_WALK;
      ST_WALK:  state_nxt = lt ? ST_WALK : ST_FIN;
      ST_PREV:  state_nxt = lt ? ST_FIN : ST_SRCH;
      ST_SRCH:  state_nxt = srch_more ? ST_SRCH : ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output logic
  always_comb begin
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    t_nxt         = t_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = 1'b0;
    out_idx_nxt   = '0;
    out_acc_nxt   = 1'b0;
    out_total_nxt = count_r;
    rd_addr       = cursor_r[CIL_IDX_W-1:0];
    srch_init     = 1'b0;
    wr.en         = 1'b0;
    wr.addr       = count_r[CIL_IDX_W-1:0];
    wr.beg_ms     = in_cue_start_ms;
    wr.end_ms     = in_cue_end_ms;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_nxt = in_query_time_ms;
          case (kind)
            KIND_CLEAR: begin
              count_nxt     = '0;
              cursor_nxt    = '0;
              out_valid_nxt = 1'b1;
              out_total_nxt = '0;
            end
            KIND_APPEND: begin
              out_valid_nxt = 1'b1;
              if (append_ok) begin
                wr.en         = 1'b1;
                count_nxt     = count_r + CIL_CNT_W'(1);
                out_acc_nxt   = 1'b1;
                out_total_nxt = count_r + CIL_CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              // Empty table: answer a miss at once, else fetch the cursor's cue
              out_valid_nxt = (count_r == '0);
            end
            KIND_CURSOR_RST: begin
              cursor_nxt    = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CUR: begin
        if (!cur_valid || lt) begin
          if (ahead_ok) begin
            rd_addr = cur_ahead[CIL_IDX_W-1:0];
          end else begin
            srch_init = 1'b1;
          end
        end else if (cursor_r != '0) begin
          rd_addr = cur_dec[CIL_IDX_W-1:0];
        end
      end
      ST_AHEAD: begin
        if (lt) begin
          srch_init = 1'b1;
        end else begin
          // Cursor's cue already known to have ended: step past it
          cursor_nxt = cur_inc;
          rd_addr    = cur_inc[CIL_IDX_W-1:0];
        end
      end
      ST_WALK: begin
        if (lt) begin
          cursor_nxt = cur_inc;
          rd_addr    = cur_inc[CIL_IDX_W-1:0];
        end
      end
      ST_PREV: begin
        // Previous cue still running: a backward seek, search again
        if (!lt) begin
          srch_init = 1'b1;
        end
      end
      ST_SRCH: begin
        lo_nxt   = lo_s;
        hi_nxt   = hi_s;
        best_nxt = best_s;
        mid_nxt  = mid_s;
        if (srch_more) begin
          rd_addr = mid_s[CIL_IDX_W-1:0];
        end else begin
          cursor_nxt = best_s;
          rd_addr    = best_s[CIL_IDX_W-1:0];
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = cur_valid && !lt && (t_r >= rd_beg_ms);
        out_idx_nxt   = out_hit_nxt ? cursor_r[CIL_IDX_W-1:0] : '0;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase

    // Open a search over the whole table and issue its first probe
    if (srch_init) begin
      lo_nxt   = '0;
      hi_nxt   = count_r;
      best_nxt = '0;
      mid_nxt  = count_r >> 1;
      rd_addr  = mid_nxt[CIL_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    best_r      <= best_nxt;
    out_hit_r   <= out_hit_nxt;
    out_idx_r   <= out_idx_nxt;
    out_acc_r   <= out_acc_nxt;
    out_total_r <= out_total_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_cue_index = out_idx_r;
  assign out_accepted  = out_acc_r;
  assign out_cue_total = out_total_r;

`ifndef SYNTHESIS
  // A result follows either an accepted transaction or the last query step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r == ST_FIN) || $past(accept)))
    else $error("result strobe without a source transaction");

  // A hit names a cue that is held
  a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> ({1'b0, out_cue_index} < out_cue_total))
    else $error("hit index beyond cue total");

  // A query in progress never runs on an empty table
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("query sequencer active on empty table");

  // The forward walk stays inside the table
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cursor_r < count_r))
    else $error("forward walk ran past the last cue");

  // The cue count holds while a query runs
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> $stable(count_r))
    else $error("cue count changed during a query");
`endif

endmodule

/* hw/rtl/cil_table.sv */
// Cue table: start and end time memories, one write and one read port each.
// Depends on cil_pkg. Read data is registered (valid in the cycle after the address).
module cil_table import cil_pkg::*; (
  input  logic                  clk,
  input  cil_wr_t               wr,
  input  logic [CIL_IDX_W-1:0]  rd_addr,
  output logic [CIL_TIME_W-1:0] rd_beg_ms,
  output logic [CIL_TIME_W-1:0] rd_end_ms
);

  logic [CIL_TIME_W-1:0] start_mem [CIL_MAX_CUES];
  logic [CIL_TIME_W-1:0] end_mem   [CIL_MAX_CUES];
  logic [CIL_TIME_W-1:0] rd_start_r;
  logic [CIL_TIME_W-1:0] rd_end_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_mem[wr.addr] <= wr.beg_ms;
      end_mem[wr.addr]   <= wr.end_ms;
    end
    rd_start_r <= start_mem[rd_addr];
    rd_end_r   <= end_mem[rd_addr];
  end

  assign rd_beg_ms = rd_start_r;
  assign rd_end_ms = rd_end_r;

endmodule

/* verif/cue_interval_lookup_top_tb.sv */
// Self-checking testbench for cue_interval_lookup_top: cue table appends, clears,
// cursor resets and time lookups, checked against an in-bench model of the table.
// Depends on cil_pkg and the cue_interval_lookup_top RTL (with cil_table) only.
`timescale 1ns / 1ps

module cue_interval_lookup_top_tb;
  import cil_pkg::*;

  // One transaction toward the block; fields that its kind ignores still carry noise.
  typedef struct {
    cil_kind_t              kind;
    logic [CIL_TIME_W-1:0]  beg_ms;
    logic [CIL_TIME_W-1:0]  end_ms;
    logic                   has_text;
    logic [CIL_TIME_W-1:0]  query_ms;
  } cue_cmd_t;

  // What the block should report for one transaction.
  typedef struct {
    logic                  hit;
    logic [CIL_IDX_W-1:0]  cue_index;
    logic                  accepted;
    logic [CIL_CNT_W-1:0]  cue_total;
  } cue_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_kind = KIND_CLEAR;
  logic [CIL_TIME_W-1:0] in_cue_start_ms = '0;
  logic [CIL_TIME_W-1:0] in_cue_end_ms = '0;
  logic                  in_cue_has_text = 1'b0;
  logic [CIL_TIME_W-1:0] in_query_time_ms = '0;
  logic                  out_valid;
  logic                  out_hit;
  logic [CIL_IDX_W-1:0]  out_cue_index;
  logic                  out_accepted;
  logic [CIL_CNT_W-1:0]  out_cue_total;

  cue_interval_lookup_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_cue_start_ms  (in_cue_start_ms),
    .in_cue_end_ms    (in_cue_end_ms),
    .in_cue_has_text  (in_cue_has_text),
    .in_query_time_ms (in_query_time_ms),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_cue_index    (out_cue_index),
    .out_accepted     (out_accepted),
    .out_cue_total    (out_cue_total)
  );

  // 10 ns clock, first rising edge at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Cue table model: its own copy of the stores, the count and the cursor.
  // ---------------------------------------------------------------------------
  logic [CIL_TIME_W-1:0] tbl_start [CIL_MAX_CUES];
  logic [CIL_TIME_W-1:0] tbl_end   [CIL_MAX_CUES];
  int                    tbl_count  = 0;
  int                    tbl_cursor = 0;

  cue_cmd_t    pending_cmds[$];      // transactions not yet taken by the block
  cue_result_t expected_results[$];  // predictions waiting for their strobe

  int err_count    = 0;
  int n_checked    = 0;
  int n_issued     = 0;
  int n_queries    = 0;
  int n_hits       = 0;
  int n_stored     = 0;
  int n_dropped    = 0;
  int peak_total   = 0;

  // Lower bound on end time: first cue that has not ended at t, or 0 if none.
  function automatic int first_unended(logic [CIL_TIME_W-1:0] t);
    int lo, hi, mid, best;
    lo   = 0;
    hi   = tbl_count;
    best = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_end[mid] < t) begin
        lo = mid + 1;
      end else begin
        best = mid;
        hi   = mid;
      end
    end
    return best;
  endfunction

  // Move the cursor for time t, then test whether the cue under it spans t.
  function automatic logic cue_spans(logic [CIL_TIME_W-1:0] t);
    int n;
    n = tbl_count;
    if (n == 0) return 1'b0;
    if (tbl_cursor >= n || tbl_end[tbl_cursor] < t) begin
      // Cursor cue has ended: walk when the cue a short hop ahead is still live.
      if (tbl_cursor < n && tbl_end[tbl_cursor] < t &&
          tbl_cursor + CIL_WALK_AHEAD < n && tbl_end[tbl_cursor + CIL_WALK_AHEAD] >= t) begin
        while (tbl_cursor < n && tbl_end[tbl_cursor] < t) tbl_cursor++;
      end else begin
        tbl_cursor = first_unended(t);
      end
    end else if (tbl_cursor > 0 && tbl_end[tbl_cursor - 1] >= t) begin
      // Backward seek: the previous cue is still live, so search again.
      tbl_cursor = first_unended(t);
    end
    if (tbl_cursor >= n) return 1'b0;
    return (t >= tbl_start[tbl_cursor]) && (t <= tbl_end[tbl_cursor]);
  endfunction

  // Advance the table model by one transaction and return the expected result.
  function automatic cue_result_t apply_cue_cmd(cue_cmd_t c);
    cue_result_t r;
    r.hit       = 1'b0;
    r.cue_index = '0;
    r.accepted  = 1'b0;
    case (c.kind)
      KIND_CLEAR: begin
        tbl_count  = 0;
        tbl_cursor = 0;
      end
      KIND_APPEND: begin
        if (c.has_text && c.end_ms > c.beg_ms && tbl_count < CIL_MAX_CUES) begin
          tbl_start[tbl_count] = c.beg_ms;
          tbl_end[tbl_count]   = c.end_ms;
          tbl_count++;
          r.accepted = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (cue_spans(c.query_ms)) begin
          r.hit       = 1'b1;
          r.cue_index = CIL_IDX_W'(tbl_cursor);
        end
      end
      default: begin
        tbl_cursor = 0;
      end
    endcase
    r.cue_total = CIL_CNT_W'(tbl_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: queue one transaction, with noise on ignored fields.
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(cil_kind_t k, logic [CIL_TIME_W-1:0] s,
                                   logic [CIL_TIME_W-1:0] e, logic txt,
                                   logic [CIL_TIME_W-1:0] q);
    cue_cmd_t c;
    c.kind     = k;
    c.beg_ms   = s;
    c.end_ms   = e;
    c.has_text = txt;
    c.query_ms = q;
    pending_cmds.push_back(c);
  endfunction

  function automatic void push_append(logic [CIL_TIME_W-1:0] s, logic [CIL_TIME_W-1:0] e,
                                      logic txt);
    push_cmd(KIND_APPEND, s, e, txt, $urandom);
  endfunction

  function automatic void push_query(logic [CIL_TIME_W-1:0] t);
    push_cmd(KIND_QUERY, $urandom, $urandom, 1'($urandom_range(0, 1)), t);
  endfunction

  function automatic void push_ctrl(cil_kind_t k);
    push_cmd(k, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
  endfunction

  // Count one line per mismatch.
  task automatic flag_mismatch(string field, logic [CIL_TIME_W-1:0] got,
                               logic [CIL_TIME_W-1:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
             $time, field, got, want, n_checked);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the head of pending_cmds in bursts separated by random gaps.
  // A transaction is taken at an edge where start is high and busy is low; the
  // model is advanced right there, so predictions stay in accept order.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_cmds
    cue_cmd_t    taken;
    cue_cmd_t    head;
    cue_result_t want;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken = pending_cmds.pop_front();
        want  = apply_cue_cmd(taken);
        expected_results.push_back(want);
        n_issued++;
        if (taken.kind == KIND_QUERY) begin
          n_queries++;
          if (want.hit) n_hits++;
        end
        if (taken.kind == KIND_APPEND) begin
          if (want.accepted) n_stored++;
          else n_dropped++;
        end
        if (int'(want.cue_total) > peak_total) peak_total = int'(want.cue_total);
      end
      // Hold the current transaction while the block is busy; otherwise pick
      // the next step. Gaps also run down during busy stretches, so idle
      // cycles land on every phase of a lookup.
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          head = pending_cmds[0];
          in_kind          <= head.kind;
          in_cue_start_ms  <= head.beg_ms;
          in_cue_end_ms    <= head.end_ms;
          in_cue_has_text  <= head.has_text;
          in_query_time_ms <= head.query_ms;
          start            <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // Mostly short bursts, now and then a long back-to-back run.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe is one result; compare it with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cue_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no transaction pending", CIL_TIME_W'(out_cue_total), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_hit !== want.hit)             flag_mismatch("hit", CIL_TIME_W'(out_hit),
                                                            CIL_TIME_W'(want.hit));
        if (out_cue_index !== want.cue_index) flag_mismatch("cue_index",
                                                            CIL_TIME_W'(out_cue_index),
                                                            CIL_TIME_W'(want.cue_index));
        if (out_accepted !== want.accepted)   flag_mismatch("accepted",
                                                            CIL_TIME_W'(out_accepted),
                                                            CIL_TIME_W'(want.accepted));
        if (out_cue_total !== want.cue_total) flag_mismatch("cue_total",
                                                            CIL_TIME_W'(out_cue_total),
                                                            CIL_TIME_W'(want.cue_total));
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all stimulus, release reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [CIL_TIME_W-1:0] seq_start[$];
    logic [CIL_TIME_W-1:0] seq_end[$];
    logic [CIL_TIME_W-1:0] base;
    logic [CIL_TIME_W-1:0] t;
    logic [CIL_TIME_W-1:0] s;
    logic [CIL_TIME_W-1:0] e;
    int rand_first;
    int ncues;
    int nq;
    int k;
    int r;
    int gen_table;
    int n_noise;
    bit fresh;

    // Directed: empty table, dropped appends, walk, search, seeks, clear.
    push_query(32'd0);                       // empty table: miss, cursor stays
    push_ctrl(KIND_CURSOR_RST);
    push_append(32'd0, 32'd10, 1'b0);        // no text: drop
    push_append(32'd5, 32'd5, 1'b1);         // zero length: drop
    push_append(32'd50, 32'd20, 1'b1);       // end before start: drop
    for (int i = 0; i < 10; i++) push_append(i * 100, i * 100 + 50, 1'b1);
    push_append(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
    push_query(32'd0);                       // hit on the cursor cue
    push_query(32'd250);                     // short walk forward, hit on end edge
    push_query(32'd260);                     // walk one more, gap: miss
    push_query(32'd1050);                    // too far to walk: binary search
    push_query(32'hFFFF_FFFF);               // top of time range
    push_query(32'd0);                       // backward seek
    push_query(32'd950);
    push_ctrl(KIND_CURSOR_RST);
    push_query(32'd450);
    push_ctrl(KIND_CLEAR);
    push_query(32'd100);                     // empty again after clear
    push_append(32'd10, 32'd20, 1'b1);
    push_query(32'd30);                      // every cue ended: cursor to 0, miss

    // Load a longer table and search it at spread-out times.
    push_ctrl(KIND_CLEAR);
    for (int i = 0; i < 48; i++) begin
      s = i * 1000;
      push_append(s, s + $urandom_range(1, 999), 1'b1);
    end
    push_query(32'd0);
    push_query(32'd12_345);
    push_query(32'd47_000);
    push_query(32'd20_500);
    for (int i = 0; i < 4; i++) push_query($urandom_range(0, 48_000));
    push_query(32'hFFFF_FFFF);
    push_ctrl(KIND_CLEAR);

    // Random traffic: mostly load-then-play sequences, some raw noise.
    rand_first = pending_cmds.size();
    gen_table  = 0;
    base       = '0;
    t          = '0;
    while (pending_cmds.size() - rand_first < 400) begin
      if ($urandom_range(0, 99) < 80) begin
        ncues = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
        fresh = ($urandom_range(0, 4) != 0) || (gen_table > 3000) || (seq_end.size() == 0);
        if (fresh) begin
          push_ctrl(KIND_CLEAR);
          seq_start.delete();
          seq_end.delete();
          gen_table = 0;
          case ($urandom_range(0, 3))
            0:       base = $urandom_range(0, 1000);
            1:       base = 32'hFFFF_FFFF - CIL_TIME_W'(ncues * 600) - $urandom_range(0, 1000);
            default: base = $urandom_range(0, 32'hFF00_0000);
          endcase
        end else begin
          base = seq_end[$];                 // keep appending after the last end
        end
        for (int i = 0; i < ncues; i++) begin
          s = base + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200));
          if ($urandom_range(0, 7) == 0 && base >= 20) s = base - $urandom_range(0, 20);
          e = base + $urandom_range(1, 300);
          if (e <= base) e = base + 1;
          if ($urandom_range(0, 19) == 0) begin
            // Broken cue inside the sequence: no text or zero length.
            if ($urandom_range(0, 1) == 0) push_append(s, e, 1'b0);
            else push_append(s, s, 1'b1);
          end else begin
            if (e <= s) e = s + 1;
            push_append(s, e, 1'b1);
            seq_start.push_back(s);
            seq_end.push_back(e);
            base = e;
          end
          gen_table++;
        end
        nq = $urandom_range(4, 30);
        t  = (seq_start.size() != 0) ? seq_start[0] - $urandom_range(0, 50) : base;
        for (int i = 0; i < nq; i++) begin
          r = $urandom_range(0, 99);
          if (seq_start.size() == 0 || r >= 95) begin
            t = base + $urandom_range(1, 1000);        // past the last cue
          end else if (r < 55) begin
            t = t + $urandom_range(0, 120);            // normal forward playback
          end else if (r < 75) begin
            k = $urandom_range(0, seq_start.size() - 1);
            case ($urandom_range(0, 3))
              0:       t = seq_start[k] - 1;
              1:       t = seq_start[k];
              2:       t = seq_end[k];
              default: t = seq_end[k] + 1;
            endcase
          end else if (r < 85) begin
            t = $urandom_range(seq_start[0], seq_end[$]);  // seek anywhere
          end else if (r < 90) begin
            t = $urandom;
          end else begin
            push_ctrl(KIND_CURSOR_RST);
            continue;
          end
          push_query(t);
        end
      end else begin
        // Noise: any kind, any field values.
        n_noise = $urandom_range(3, 12);
        for (int i = 0; i < n_noise; i++) begin
          push_cmd(cil_kind_t'($urandom_range(0, 3)), $urandom, $urandom,
                   1'($urandom_range(0, 1)), $urandom);
          if (pending_cmds[$].kind == KIND_CLEAR) begin
            seq_start.delete();
            seq_end.delete();
            gen_table = 0;
          end else if (pending_cmds[$].kind == KIND_APPEND) begin
            gen_table++;
          end
        end
      end
    end

    // Hold reset, then release it and let the driver go.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all transactions taken and every prediction checked, then idle a bit.
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("run covered %0d transactions: %0d queries with %0d hits, %0d cues stored,",
             n_issued, n_queries, n_hits, n_stored);
    $display("%0d appends dropped, table peak %0d of %0d entries, %0d results checked",
             n_dropped, peak_total, CIL_MAX_CUES, n_checked);
    if (err_count == 0) begin
      $display("cue_interval_lookup_top_tb: clean");
    end else begin
      $display("cue_interval_lookup_top_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d transactions pending and %0d results outstanding",
             pending_cmds.size(), expected_results.size());
    $display("cue_interval_lookup_top_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cil_pkg.sv
hw/rtl/cil_table.sv
hw/rtl/cue_interval_lookup_top.sv
verif/cue_interval_lookup_top_tb.sv
